// ----- hdl/ssp_pkg.sv -----
// Shared types and constants for the stepper shaker pulse generator.
// Event codes, controller/datapath command and status bundles, ramp constants.
// No dependencies.
package ssp_pkg;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_COMPARE = 2'd1,
      OP_TICK    = 2'd2,
      OP_STOP    = 2'd3
   } op_type;

   // rpm thresholds for microstep selection, full step down to 1/32
   localparam int unsigned RPM_FULL         = 1300;
   localparam int unsigned RPM_HALF         = 800;
   localparam int unsigned RPM_QUARTER      = 400;
   localparam int unsigned RPM_EIGHTH       = 200;
   localparam int unsigned RPM_SIXTEENTH    = 100;
   localparam int unsigned RPM_THIRTYSECOND = 50;

   localparam int unsigned MSHIFT_W           = 3;
   localparam int unsigned MSHIFT_MAX         = 5;
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam logic [15:0] PERIOD_MAX         = 16'hFFFF;

   // x / 5 for 16-bit x as (x * FIFTH_RECIP) >> FIFTH_SHIFT
   localparam int unsigned FIFTH_RECIP = 52429;
   localparam int unsigned FIFTH_SHIFT = 18;

   typedef struct packed {
      logic latch;
      logic exec;
      logic prep;
      logic div_start;
      logic sat;
      logic finish;
      logic capture;
   } ssp_cmd_type;

   typedef struct packed {
      logic start_ok;
      logic div_busy;
      logic out_free;
   } ssp_status_type;

endpackage

// ----- hdl/ssp_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Payload fields match the event and result items; no dependencies.
interface ssp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] shaft_rpm;
   logic [15:0] run_seconds;
   logic        turn_direction;

   modport source (output valid, output operation, output shaft_rpm, output run_seconds,
                   output turn_direction, input ready);
   modport sink   (input valid, input operation, input shaft_rpm, input run_seconds,
                   input turn_direction, output ready);
endinterface

interface ssp_rsp_if;
   logic        valid;
   logic        ready;
   logic        step_level;
   logic        direction_level;
   logic        driver_enable;
   logic [2:0]  microstep_code;
   logic [15:0] current_period;
   logic [15:0] target_period;
   logic        timer_active;
   logic        run_active;
   logic        start_rejected;

   modport source (output valid, output step_level, output direction_level,
                   output driver_enable, output microstep_code, output current_period,
                   output target_period, output timer_active, output run_active,
                   output start_rejected, input ready);
   modport sink   (input valid, input step_level, input direction_level,
                   input driver_enable, input microstep_code, input current_period,
                   input target_period, input timer_active, input run_active,
                   input start_rejected, output ready);
endinterface

// ----- hdl/ssp_divider.sv -----
// Restoring divider, one quotient bit per cycle, constant dividend.
// Depends on nothing; used by ssp_datapath for the target period.
module ssp_divider #(
   parameter longint unsigned DIVIDEND = 60000000,
   parameter int unsigned     DSR_W    = 26
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DSR_W-1:0]                  divisor,
   output logic [$clog2(DIVIDEND + 1)-1:0]   quotient,
   output logic                              busy
);

   localparam int unsigned DVD_W = $clog2(DIVIDEND + 1);
   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W:0]   shifted;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      fits    = shifted >= {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = DVD_W'(DIVIDEND);
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? DSR_W'(shifted - {1'b0, divisor}) : DSR_W'(shifted);
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign busy     = cnt_ff != '0;

endmodule

// ----- hdl/ssp_datapath.sv -----
// Datapath: drive state, period arithmetic, countdown and the response register.
// Uses ssp_pkg, ssp_rsp_if and ssp_divider; steered by ssp_ctrl commands.
module ssp_datapath import ssp_pkg::*; #(
   parameter int unsigned STEPS_PER_ROUND  = 200,
   parameter int unsigned TICKS_PER_SECOND = 1000,
   parameter int unsigned TIMER_HZ         = 1000000
) (
   input  logic           clock,
   input  logic           reset,
   input  ssp_cmd_type    cmd,
   output ssp_status_type status,
   input  logic [1:0]     req_operation,
   input  logic [15:0]    req_shaft_rpm,
   input  logic [15:0]    req_run_seconds,
   input  logic           req_turn_direction,
   ssp_rsp_if.source      rsp_bus
);

   localparam longint unsigned DIVIDEND    = 64'(SECONDS_PER_MINUTE) * 64'(TIMER_HZ);
   localparam longint unsigned DIVISOR_MAX =
      64'(16'hFFFF) * 64'(STEPS_PER_ROUND) * (64'd1 << MSHIFT_MAX);
   localparam longint unsigned TICKS_MAX   = 64'(16'hFFFF) * 64'(TICKS_PER_SECOND);
   localparam int unsigned     DVD_W       = $clog2(DIVIDEND + 1);
   localparam int unsigned     DSR_W       = $clog2(DIVISOR_MAX + 1);
   localparam int unsigned     TICK_W      = $clog2(TICKS_MAX + 1);

   typedef struct packed {
      logic                step_level;
      logic                direction_level;
      logic                driver_enable;
      logic [MSHIFT_W-1:0] microstep_code;
      logic [15:0]         current_period;
      logic [15:0]         target_period;
      logic                timer_active;
      logic                run_active;
      logic                start_rejected;
   } rsp_data_type;

   function automatic logic [MSHIFT_W-1:0] pick_shift(input logic [15:0] rpm,
                                                     input logic [MSHIFT_W-1:0] prev);
      logic [MSHIFT_W-1:0] sel;
      sel = prev;
      if (rpm >= 16'(RPM_FULL))              sel = MSHIFT_W'(0);
      else if (rpm >= 16'(RPM_HALF))         sel = MSHIFT_W'(1);
      else if (rpm >= 16'(RPM_QUARTER))      sel = MSHIFT_W'(2);
      else if (rpm >= 16'(RPM_EIGHTH))       sel = MSHIFT_W'(3);
      else if (rpm >= 16'(RPM_SIXTEENTH))    sel = MSHIFT_W'(4);
      else if (rpm >= 16'(RPM_THIRTYSECOND)) sel = MSHIFT_W'(5);
      return sel;
   endfunction

   // latched request
   op_type      op_ff, op_in;
   logic [15:0] rpm_ff, rpm_in;
   logic [15:0] secs_ff, secs_in;
   logic        dir_ff, dir_in;

   // drive state
   logic                step_ff, step_in;
   logic                dir_pin_ff, dir_pin_in;
   logic                enable_ff, enable_in;
   logic [MSHIFT_W-1:0] mshift_ff, mshift_in;
   logic                pending_ff, pending_in;
   logic [15:0]         reload_ff, reload_in;
   logic [15:0]         goal_ff, goal_in;
   logic [TICK_W-1:0]   ticks_ff, ticks_in;
   logic                countdown_ff, countdown_in;
   logic                timer_ff, timer_in;
   logic                reject_ff, reject_in;

   // period arithmetic
   logic [DSR_W-1:0]    divisor_ff, divisor_in;
   logic [31:0]         fifth_ff, fifth_in;
   logic [DVD_W-1:0]    quotient;
   logic                div_busy;
   logic [63:0]         quo_wide;
   logic [15:0]         quo_sat;
   logic [16:0]         start_sum;
   logic [MSHIFT_W-1:0] shift_new;

   rsp_data_type        rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   ssp_divider #(
      .DIVIDEND (DIVIDEND),
      .DSR_W    (DSR_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (divisor_ff),
      .quotient (quotient),
      .busy     (div_busy)
   );

   always_comb begin
      quo_wide  = 64'(quotient);
      quo_sat   = (quo_wide > 64'(PERIOD_MAX)) ? PERIOD_MAX : quo_wide[15:0];
      start_sum = {1'b0, goal_ff} + 17'(fifth_ff >> FIFTH_SHIFT);
      shift_new = pick_shift(rpm_ff, mshift_ff);

      op_in        = op_ff;
      rpm_in       = rpm_ff;
      secs_in      = secs_ff;
      dir_in       = dir_ff;
      step_in      = step_ff;
      dir_pin_in   = dir_pin_ff;
      enable_in    = enable_ff;
      mshift_in    = mshift_ff;
      pending_in   = pending_ff;
      reload_in    = reload_ff;
      goal_in      = goal_ff;
      ticks_in     = ticks_ff;
      countdown_in = countdown_ff;
      timer_in     = timer_ff;
      reject_in    = reject_ff;
      divisor_in   = divisor_ff;
      fifth_in     = fifth_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (cmd.latch) begin
         op_in   = op_type'(req_operation);
         rpm_in  = req_shaft_rpm;
         secs_in = req_run_seconds;
         dir_in  = req_turn_direction;
      end

      if (cmd.exec) begin
         reject_in = 1'b0;
         case (op_ff)
            OP_START: begin
               reject_in = 1'b1;
            end
            OP_COMPARE: begin
               if (timer_ff) begin
                  if (!pending_ff) begin
                     enable_in = 1'b0;
                     timer_in  = 1'b0;
                  end else begin
                     step_in = !step_ff;
                     if (reload_ff > goal_ff) reload_in = reload_ff - 16'd1;
                  end
               end
            end
            OP_TICK: begin
               if (countdown_ff) begin
                  if (ticks_ff <= TICK_W'(1)) begin
                     pending_in   = 1'b0;
                     enable_in    = 1'b0;
                     countdown_in = 1'b0;
                     ticks_in     = '0;
                  end else begin
                     ticks_in = ticks_ff - 1'b1;
                  end
               end
            end
            default: begin
               pending_in   = 1'b0;
               enable_in    = 1'b0;
               countdown_in = 1'b0;
               ticks_in     = '0;
            end
         endcase
      end

      if (cmd.prep) begin
         reject_in  = 1'b0;
         enable_in  = 1'b1;
         dir_pin_in = dir_ff;
         mshift_in  = shift_new;
         divisor_in = DSR_W'(DSR_W'(rpm_ff) * DSR_W'(STEPS_PER_ROUND)) << shift_new;
         ticks_in   = TICK_W'(secs_ff) * TICK_W'(TICKS_PER_SECOND);
      end

      if (cmd.sat) begin
         goal_in  = quo_sat;
         fifth_in = 32'(quo_sat) * 32'(FIFTH_RECIP);
      end

      // arm the timer; a zero run time ends the run right away
      if (cmd.finish) begin
         reload_in = start_sum[16] ? PERIOD_MAX : start_sum[15:0];
         timer_in  = 1'b1;
         if (ticks_ff == '0) begin
            pending_in   = 1'b0;
            enable_in    = 1'b0;
            countdown_in = 1'b0;
         end else begin
            pending_in   = 1'b1;
            countdown_in = 1'b1;
         end
      end

      if (cmd.capture) begin
         rsp_in.step_level      = step_ff;
         rsp_in.direction_level = dir_pin_ff;
         rsp_in.driver_enable   = enable_ff;
         rsp_in.microstep_code  = mshift_ff;
         rsp_in.current_period  = reload_ff;
         rsp_in.target_period   = goal_ff;
         rsp_in.timer_active    = timer_ff;
         rsp_in.run_active      = countdown_ff;
         rsp_in.start_rejected  = reject_ff;
         rsp_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 1'b0;
         dir_pin_ff   <= 1'b0;
         enable_ff    <= 1'b0;
         mshift_ff    <= '0;
         pending_ff   <= 1'b0;
         reload_ff    <= '0;
         goal_ff      <= '0;
         ticks_ff     <= '0;
         countdown_ff <= 1'b0;
         timer_ff     <= 1'b0;
         reject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         dir_pin_ff   <= dir_pin_in;
         enable_ff    <= enable_in;
         mshift_ff    <= mshift_in;
         pending_ff   <= pending_in;
         reload_ff    <= reload_in;
         goal_ff      <= goal_in;
         ticks_ff     <= ticks_in;
         countdown_ff <= countdown_in;
         timer_ff     <= timer_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      rpm_ff     <= rpm_in;
      secs_ff    <= secs_in;
      dir_ff     <= dir_in;
      divisor_ff <= divisor_in;
      fifth_ff   <= fifth_in;
      rsp_ff     <= rsp_in;
   end

   assign status.start_ok = (op_ff == OP_START) && !countdown_ff && (rpm_ff != 16'd0);
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.step_level      = rsp_ff.step_level;
   assign rsp_bus.direction_level = rsp_ff.direction_level;
   assign rsp_bus.driver_enable   = rsp_ff.driver_enable;
   assign rsp_bus.microstep_code  = rsp_ff.microstep_code;
   assign rsp_bus.current_period  = rsp_ff.current_period;
   assign rsp_bus.target_period   = rsp_ff.target_period;
   assign rsp_bus.timer_active    = rsp_ff.timer_active;
   assign rsp_bus.run_active      = rsp_ff.run_active;
   assign rsp_bus.start_rejected  = rsp_ff.start_rejected;

   a_run_armed: assert property (@(posedge clock) disable iff (reset)
      countdown_ff |-> (pending_ff && enable_ff && timer_ff && ticks_ff != '0))
      else $error("run active without armed drive state");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      mshift_ff <= MSHIFT_W'(MSHIFT_MAX))
      else $error("microstep shift out of range");

   // goal and reload part ways while a start loads them: goal at sat, reload at finish
   a_ramp_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> reload_ff >= goal_ff)
      else $error("step period below ramp target");

   a_divisor_hold: assert property (@(posedge clock) disable iff (reset)
      div_busy |=> $stable(divisor_ff))
      else $error("divisor changed during division");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("response register overwritten before it was taken");

endmodule

// ----- hdl/ssp_ctrl.sv -----
// Controller state machine: sequences one request through the datapath.
// Uses ssp_pkg command and status bundles.
module ssp_ctrl import ssp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ssp_status_type status,
   output ssp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SAT,
      ST_FINISH,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.start_ok) begin
               cmd.prep = 1'b1;
               state_in = ST_DIV_GO;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the response register frees up
            if (status.out_free) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/stepper_shaker_pulse_generator_unit.sv -----
// Top level of the stepper shaker pulse generator: controller plus datapath.
// Uses ssp_pkg, ssp_if, ssp_ctrl and ssp_datapath.
//
//   channel  | dir | modport | carries
//   ---------+-----+---------+---------------------------------------------
//   req_bus  | in  | sink    | operation, shaft_rpm, run_seconds, turn_direction
//   rsp_bus  | out | source  | pin levels, microstep code, periods, status
//
// Compare, tick, stop and refused start pass through EXEC and OUT once the request
// is taken. Accepted start: EXEC, DIV_GO, DIV_WAIT, SAT, FINISH and OUT, waiting in
// DIV_WAIT on the one-bit-per-cycle restoring divider for the target period.
// One request is in flight at a time; the next is taken in the cycle after the
// response is loaded, even while that response still waits in the output register.
// Synchronous active-high reset clears all drive state to idle.
module stepper_shaker_pulse_generator_unit import ssp_pkg::*; #(
   parameter int unsigned STEPS_PER_ROUND  = 200,
   parameter int unsigned TICKS_PER_SECOND = 1000,
   parameter int unsigned TIMER_HZ         = 1000000
) (
   input  logic      clock,
   input  logic      reset,
   ssp_req_if.sink   req_bus,
   ssp_rsp_if.source rsp_bus
);

   ssp_cmd_type    cmd;
   ssp_status_type status;
   logic           ready;

   ssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssp_datapath #(
      .STEPS_PER_ROUND  (STEPS_PER_ROUND),
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .TIMER_HZ         (TIMER_HZ)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_bus.operation),
      .req_shaft_rpm      (req_bus.shaft_rpm),
      .req_run_seconds    (req_bus.run_seconds),
      .req_turn_direction (req_bus.turn_direction),
      .rsp_bus            (rsp_bus)
   );

   assign req_bus.ready = ready;

endmodule

// ----- tb/sv/ssp_checker.sv -----
`timescale 1ns / 100ps
// Response checker for the stepper shaker pulse generator: predicts each response
// from the accepted requests and compares it field by field. Uses ssp_pkg and the
// request/response interfaces from ssp_if.
module ssp_checker import ssp_pkg::*; #(
   parameter int unsigned STEPS_PER_ROUND  = 200,
   parameter int unsigned TICKS_PER_SECOND = 1000,
   parameter int unsigned TIMER_HZ         = 1000000
) (
   input  logic clock,
   input  logic reset,
   ssp_req_if   req_bus,
   ssp_rsp_if   rsp_bus,
   output int   fail_count,
   output int   expected_left,
   output int   results_checked
);

   typedef struct packed {
      logic        step_level;
      logic        direction_level;
      logic        driver_enable;
      logic [2:0]  microstep_code;
      logic [15:0] current_period;
      logic [15:0] target_period;
      logic        timer_active;
      logic        run_active;
      logic        start_rejected;
   } pin_view_type;

   pin_view_type pending_views[$];

   // predicted drive state
   logic        step_q;
   logic        dir_q;
   logic        enable_q;
   logic [2:0]  shift_q;
   logic        steps_due;
   logic [15:0] period_q;
   logic [15:0] goal_q;
   logic [31:0] ticks_q;
   logic        countdown_q;
   logic        timer_q;

   function automatic logic [15:0] clamp_period(longint unsigned value);
      return (value > 64'(PERIOD_MAX)) ? PERIOD_MAX : value[15:0];
   endfunction

   // the step timer keeps running until its next compare finds nothing to do
   function void stop_drive();
      steps_due   = 1'b0;
      enable_q    = 1'b0;
      countdown_q = 1'b0;
      ticks_q     = '0;
   endfunction

   function pin_view_type apply_event(op_type op, logic [15:0] rpm, logic [15:0] secs,
                                      logic dir);
      longint unsigned divisor;
      longint unsigned quotient;
      logic            refused;
      refused = 1'b0;
      case (op)
         OP_START: begin
            if (countdown_q || rpm == 16'd0) begin
               refused = 1'b1;
            end else begin
               enable_q = 1'b1;
               dir_q    = dir;
               // below the lowest threshold the previous factor stays
               if (rpm >= RPM_FULL) shift_q = 3'd0;
               else if (rpm >= RPM_HALF) shift_q = 3'd1;
               else if (rpm >= RPM_QUARTER) shift_q = 3'd2;
               else if (rpm >= RPM_EIGHTH) shift_q = 3'd3;
               else if (rpm >= RPM_SIXTEENTH) shift_q = 3'd4;
               else if (rpm >= RPM_THIRTYSECOND) shift_q = 3'd5;
               divisor   = (64'(rpm) * 64'(STEPS_PER_ROUND)) << shift_q;
               quotient  = 64'(SECONDS_PER_MINUTE) * 64'(TIMER_HZ) / divisor;
               goal_q    = clamp_period(quotient);
               period_q  = clamp_period(quotient + quotient / 5);
               steps_due = 1'b1;
               timer_q   = 1'b1;
               ticks_q   = 32'(64'(secs) * 64'(TICKS_PER_SECOND));
               countdown_q = 1'b1;
               if (ticks_q == 32'd0) stop_drive();
            end
         end
         OP_COMPARE: begin
            if (timer_q) begin
               if (!steps_due) begin
                  enable_q = 1'b0;
                  timer_q  = 1'b0;
               end else begin
                  step_q = ~step_q;
                  if (period_q > goal_q) period_q = period_q - 16'd1;
               end
            end
         end
         OP_TICK: begin
            if (countdown_q) begin
               if (ticks_q != 32'd0) ticks_q = ticks_q - 32'd1;
               if (ticks_q == 32'd0) stop_drive();
            end
         end
         OP_STOP: begin
            stop_drive();
         end
      endcase
      return '{step_level: step_q, direction_level: dir_q, driver_enable: enable_q,
               microstep_code: shift_q, current_period: period_q,
               target_period: goal_q, timer_active: timer_q,
               run_active: countdown_q, start_rejected: refused};
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pin_view_type got;
      pin_view_type want;
      if (reset) begin
         step_q      = 1'b0;
         dir_q       = 1'b0;
         enable_q    = 1'b0;
         shift_q     = 3'd0;
         steps_due   = 1'b0;
         period_q    = '0;
         goal_q      = '0;
         ticks_q     = '0;
         countdown_q = 1'b0;
         timer_q     = 1'b0;
         pending_views.delete();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         // retire the response first: it can never belong to a request taken on this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{step_level: rsp_bus.step_level,
                    direction_level: rsp_bus.direction_level,
                    driver_enable: rsp_bus.driver_enable,
                    microstep_code: rsp_bus.microstep_code,
                    current_period: rsp_bus.current_period,
                    target_period: rsp_bus.target_period,
                    timer_active: rsp_bus.timer_active,
                    run_active: rsp_bus.run_active,
                    start_rejected: rsp_bus.start_rejected};
            if (pending_views.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = pending_views.pop_front();
               check_field("step_level", 16'(want.step_level), 16'(got.step_level));
               check_field("direction_level", 16'(want.direction_level),
                           16'(got.direction_level));
               check_field("driver_enable", 16'(want.driver_enable),
                           16'(got.driver_enable));
               check_field("microstep_code", 16'(want.microstep_code),
                           16'(got.microstep_code));
               check_field("current_period", want.current_period, got.current_period);
               check_field("target_period", want.target_period, got.target_period);
               check_field("timer_active", 16'(want.timer_active), 16'(got.timer_active));
               check_field("run_active", 16'(want.run_active), 16'(got.run_active));
               check_field("start_rejected", 16'(want.start_rejected),
                           16'(got.start_rejected));
               results_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_views.push_back(apply_event(op_type'(req_bus.operation),
                                                req_bus.shaft_rpm, req_bus.run_seconds,
                                                req_bus.turn_direction));
         end
      end
      expected_left = pending_views.size();
   end

endmodule

// ----- tb/sv/tb_stepper_shaker_pulse_generator_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for stepper_shaker_pulse_generator_unit: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on ssp_pkg, ssp_if and
// ssp_checker, which predicts and compares every response.
module tb_stepper_shaker_pulse_generator_unit;
   import ssp_pkg::*;

   localparam int unsigned STEPS_PER_ROUND  = 200;
   localparam int unsigned TICKS_PER_SECOND = 1000;
   localparam int unsigned TIMER_HZ         = 1000000;
   localparam int          ITEM_TARGET      = 1950;
   localparam int          TAIL_CYCLES      = 64;
   localparam int          RUN_LIMIT        = 3000000;

   logic clock;
   logic reset;
   logic req_taken = 1'b0;
   int   cycle_count = 0;
   int   fail_count;
   int   expected_left;
   int   results_checked;
   int   requests_sent = 0;
   int   op_count[4] = '{0, 0, 0, 0};
   bit   steady_send = 1'b0;
   bit   steady_recv = 1'b0;
   bit   countdown_done = 1'b0;
   int   recv_stall;

   ssp_req_if req_bus ();
   ssp_rsp_if rsp_bus ();

   stepper_shaker_pulse_generator_unit #(
      .STEPS_PER_ROUND (STEPS_PER_ROUND),
      .TICKS_PER_SECOND(TICKS_PER_SECOND),
      .TIMER_HZ        (TIMER_HZ)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   ssp_checker #(
      .STEPS_PER_ROUND (STEPS_PER_ROUND),
      .TICKS_PER_SECOND(TICKS_PER_SECOND),
      .TIMER_HZ        (TIMER_HZ)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .fail_count     (fail_count),
      .expected_left  (expected_left),
      .results_checked(results_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken   <= req_bus.valid && req_bus.ready && !reset;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 31);
      if (roll < 22) return 0;
      if (roll < 28) return $urandom_range(1, 3);
      if (roll < 31) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // threshold edges, idle-factor speeds and the full field range
   function automatic logic [15:0] pick_speed();
      int unsigned edges[12] = '{49, 50, 99, 100, 199, 200, 399, 400, 799, 800, 1299, 1300};
      case ($urandom_range(0, 7))
         0: return 16'(edges[$urandom_range(0, 11)]);
         1: return 16'd0;
         2: return 16'($urandom_range(1, 49));
         3, 4: return 16'($urandom_range(50, 1999));
         5: return 16'($urandom_range(2000, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_seconds();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'($urandom_range(1, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send(op_type op, logic [15:0] rpm, logic [15:0] secs, logic dir);
      int idle;
      idle = steady_send ? 0 : pick_gap();
      if (idle > 0) begin
         req_bus.valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_bus.operation      = op;
      req_bus.shaft_rpm      = rpm;
      req_bus.run_seconds    = secs;
      req_bus.turn_direction = dir;
      req_bus.valid          = 1'b1;
      do @(negedge clock); while (!req_taken);
      requests_sent++;
      op_count[op]++;
   endtask

   task automatic send_junk(op_type op);
      send(op, 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic drain_responses();
      req_bus.valid = 1'b0;
      while (expected_left != 0) @(negedge clock);
   endtask

   // response side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      recv_stall = 0;
      forever begin
         @(negedge clock);
         if (recv_stall > 0) begin
            rsp_bus.ready = 1'b0;
            recv_stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!steady_recv) recv_stall = pick_gap();
         end
         if ($urandom_range(0, 299) == 0) steady_recv = !steady_recv;
      end
   end

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               expected_left);
      $display("[stepper_shaker_pulse_generator_unit] ERROR");
      $finish;
   end

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.operation      = OP_START;
      req_bus.shaft_rpm      = '0;
      req_bus.run_seconds    = '0;
      req_bus.turn_direction = 1'b0;
      reset = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // idle events, refused starts, saturated periods, zero run time, held factor
      send(OP_COMPARE, 16'hFFFF, 16'hFFFF, 1'b1);
      send(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
      send(OP_STOP, 16'hFFFF, 16'hFFFF, 1'b1);
      send(OP_START, 16'd0, 16'd5, 1'b1);
      send(OP_START, 16'd1, 16'hFFFF, 1'b1);
      send(OP_START, 16'd1000, 16'd3, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_TICK, 16'd0, 16'd0, 1'b0);
      send(OP_STOP, 16'd0, 16'd0, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_START, 16'hFFFF, 16'd0, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_START, 16'd50, 16'd1, 1'b1);
      repeat (3) send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_TICK, 16'd0, 16'd0, 1'b0);
      send(OP_STOP, 16'd0, 16'd0, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_START, 16'd49, 16'd2, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      send(OP_STOP, 16'd0, 16'd0, 1'b0);
      send(OP_COMPARE, 16'd0, 16'd0, 1'b0);
      drain_responses();

      while (requests_sent < ITEM_TARGET) begin
         steady_send = ($urandom_range(0, 3) == 0);
         if (!countdown_done && requests_sent >= 400) begin
            // one full second of ticks so the countdown expires by itself
            send(OP_START, 16'($urandom_range(50, 1999)), 16'd1, 1'($urandom));
            repeat (TICKS_PER_SECOND) begin
               if ($urandom_range(0, 7) == 0) send_junk(OP_COMPARE);
               send_junk(OP_TICK);
            end
            repeat (2) send_junk(OP_COMPARE);
            countdown_done = 1'b1;
         end else begin
            if ($urandom_range(0, 5) == 0) send_junk(op_type'($urandom_range(0, 3)));
            send(OP_START, pick_speed(), pick_seconds(), 1'($urandom));
            repeat ($urandom_range(4, 70)) begin
               case ($urandom_range(0, 19))
                  13, 14, 15, 16: send_junk(OP_TICK);
                  17: send(OP_START, pick_speed(), pick_seconds(), 1'($urandom));
                  18, 19: send_junk(op_type'($urandom_range(0, 3)));
                  default: send_junk(OP_COMPARE);
               endcase
            end
            if ($urandom_range(0, 9) != 0) send_junk(OP_STOP);
            repeat ($urandom_range(1, 2)) send_junk(OP_COMPARE);
         end
         if ($urandom_range(0, 11) == 0) drain_responses();
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d requests (%0d start, %0d compare, %0d tick, %0d stop),",
               requests_sent, op_count[OP_START], op_count[OP_COMPARE], op_count[OP_TICK],
               op_count[OP_STOP]);
      $display("checked %0d responses over refused starts, rpm thresholds,",
               results_checked);
      $display("saturated periods, ramps and run ends.");
      if (fail_count == 0) begin
         $display("[stepper_shaker_pulse_generator_unit] OK");
      end else begin
         $display("[stepper_shaker_pulse_generator_unit] ERROR");
      end
      $finish;
   end

endmodule
